@@ sv/bkv_pkg.sv @@
// ----------------------------------------------------------------------------
// bkv_pkg
// shared types and constants of the bounded key/value table
// ----------------------------------------------------------------------------
`default_nettype none

package bkv_pkg;

  // table geometry
  localparam int TABLE_ENTRIES = 15;
  localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);

  // item field widths
  localparam int OP_W     = 2;
  localparam int KEY_W    = 16;
  localparam int DATA_W   = 32;
  localparam int STATUS_W = 2;
  localparam int ECOUNT_W = 4;

  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(TABLE_ENTRIES);

  // opcodes
  localparam logic [OP_W-1:0] OP_SET    = 2'd0;
  localparam logic [OP_W-1:0] OP_GET    = 2'd1;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_FOUND    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_ABSENT   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_INSERTED = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0]   opcode;
    logic [KEY_W-1:0]  key;
    logic [DATA_W-1:0] data_in;
  } bkv_in_t;

  typedef struct packed {
    logic [DATA_W-1:0]   data_out;
    logic [STATUS_W-1:0] status;
    logic [ECOUNT_W-1:0] entry_count;
  } bkv_out_t;

  // request from the sequencer to the entry store
  typedef struct packed {
    logic              kwe;
    logic              vwe;
    logic [IDX_W-1:0]  waddr;
    logic [KEY_W-1:0]  wkey;
    logic [DATA_W-1:0] wval;
    logic              re;
    logic [IDX_W-1:0]  raddr;
  } bkv_mem_req_t;

endpackage

`default_nettype wire

@@ sv/bkv_store.sv @@
// ----------------------------------------------------------------------------
// bkv_store
// key and value memories, one write and one registered read port each
// ----------------------------------------------------------------------------
`default_nettype none

module bkv_store (
  input  wire logic                      clk,
  input  wire bkv_pkg::bkv_mem_req_t     req,
  output logic [bkv_pkg::KEY_W-1:0]      rkey,
  output logic [bkv_pkg::DATA_W-1:0]     rval
);

  logic [bkv_pkg::KEY_W-1:0]  key_mem [bkv_pkg::TABLE_ENTRIES];
  logic [bkv_pkg::DATA_W-1:0] val_mem [bkv_pkg::TABLE_ENTRIES];

  // write ports
  always_ff @(posedge clk) begin
    if (req.kwe) begin
      key_mem[req.waddr] <= req.wkey;
    end
    if (req.vwe) begin
      val_mem[req.waddr] <= req.wval;
    end
  end

  // read ports, registered
  always_ff @(posedge clk) begin
    if (req.re) begin
      rkey <= key_mem[req.raddr];
      rval <= val_mem[req.raddr];
    end
  end

endmodule

`default_nettype wire

@@ sv/bounded_key_value_table_core.sv @@
// ----------------------------------------------------------------------------
// bounded_key_value_table_core
// small associative table of key/value pairs scanned out of on-chip memory
// ----------------------------------------------------------------------------
// usage
//   input channel: present an item on in_item and raise start while busy is
//   low; the item is taken at that clock edge and busy stays high until the
//   result is out. opcodes: set, get, remove; any other code is a no-op.
//   result channel: out_valid is high for exactly one cycle with out_item;
//   the receiver must take it then, there is no back pressure.
// scan
//   the keys are read from memory one entry per cycle and compared in the
//   cycle after each read. a hit ends the scan, a miss compares every valid
//   entry; get and remove hits add a second memory read. the result strobe
//   is registered and busy drops in the same cycle, so a new item may be
//   started while the result is shown.
// reset
//   synchronous active-low reset empties the table (count zero); memory
//   contents are not cleared, only slots below the count are ever read
// ----------------------------------------------------------------------------
`default_nettype none

module bounded_key_value_table_core (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire bkv_pkg::bkv_in_t  in_item,
  output logic                   out_valid,
  output bkv_pkg::bkv_out_t      out_item
);

  // sequencer states
  localparam logic [1:0] S_IDLE  = 2'd0;  // waiting for an item
  localparam logic [1:0] S_SCAN  = 2'd1;  // key search, one entry per cycle
  localparam logic [1:0] S_VREAD = 2'd2;  // get hit, value read in flight
  localparam logic [1:0] S_MOVE  = 2'd3;  // remove hit, last entry read in flight

  logic [1:0]                 state_r, state_nxt;
  logic [bkv_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;        // valid entries
  logic [bkv_pkg::CNT_W-1:0]  rd_idx_r, rd_idx_nxt;  // next slot to read
  logic [bkv_pkg::IDX_W-1:0]  cmp_idx_r, cmp_idx_nxt; // slot of key in rkey
  logic [bkv_pkg::IDX_W-1:0]  slot_r, slot_nxt;      // slot freed by remove
  logic                       pend_v_r, pend_v_nxt;  // rkey holds a fresh key
  bkv_pkg::bkv_in_t           in_r, in_nxt;
  logic                       out_valid_r, out_valid_nxt;
  bkv_pkg::bkv_out_t          out_r, out_nxt;

  bkv_pkg::bkv_mem_req_t      mem_req;
  logic [bkv_pkg::KEY_W-1:0]  rkey;
  logic [bkv_pkg::DATA_W-1:0] rval;

  logic                       hit;
  logic [bkv_pkg::CNT_W-1:0]  last;

  bkv_store u_store (
    .clk  (clk),
    .req  (mem_req),
    .rkey (rkey),
    .rval (rval)
  );

  // key returned this cycle matches the request
  assign hit  = pend_v_r && (rkey == in_r.key);
  assign last = cnt_r - 1'b1;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    rd_idx_nxt    = rd_idx_r;
    cmp_idx_nxt   = cmp_idx_r;
    slot_nxt      = slot_r;
    pend_v_nxt    = pend_v_r;
    in_nxt        = in_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;

    mem_req       = '0;
    mem_req.raddr = rd_idx_r[bkv_pkg::IDX_W-1:0];
    mem_req.wkey  = in_r.key;
    mem_req.wval  = in_r.data_in;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          in_nxt     = in_item;
          rd_idx_nxt = '0;
          pend_v_nxt = 1'b0;
          state_nxt  = S_SCAN;
        end
      end

      S_SCAN: begin
        if (hit) begin
          pend_v_nxt = 1'b0;
          case (in_r.opcode)
            bkv_pkg::OP_SET: begin
              // overwrite value in place
              mem_req.vwe          = 1'b1;
              mem_req.waddr        = cmp_idx_r;
              out_nxt.data_out     = '0;
              out_nxt.status       = bkv_pkg::ST_FOUND;
              out_nxt.entry_count  = bkv_pkg::ECOUNT_W'(cnt_r);
              out_valid_nxt        = 1'b1;
              state_nxt            = S_IDLE;
            end
            bkv_pkg::OP_GET: begin
              mem_req.re    = 1'b1;
              mem_req.raddr = cmp_idx_r;
              state_nxt     = S_VREAD;
            end
            bkv_pkg::OP_REMOVE: begin
              // fetch the last entry, it moves into the freed slot
              mem_req.re    = 1'b1;
              mem_req.raddr = last[bkv_pkg::IDX_W-1:0];
              slot_nxt      = cmp_idx_r;
              state_nxt     = S_MOVE;
            end
            default: begin
              // unused opcode: no operation
              out_nxt.data_out    = '0;
              out_nxt.status      = bkv_pkg::ST_ABSENT;
              out_nxt.entry_count = bkv_pkg::ECOUNT_W'(cnt_r);
              out_valid_nxt       = 1'b1;
              state_nxt           = S_IDLE;
            end
          endcase
        end else if (rd_idx_r == cnt_r) begin
          // every valid entry compared, key absent
          out_nxt.data_out    = '0;
          out_nxt.entry_count = bkv_pkg::ECOUNT_W'(cnt_r);
          if (in_r.opcode == bkv_pkg::OP_SET) begin
            if (cnt_r < bkv_pkg::FULL_CNT) begin
              // append at the end of the table
              mem_req.kwe         = 1'b1;
              mem_req.vwe         = 1'b1;
              mem_req.waddr       = cnt_r[bkv_pkg::IDX_W-1:0];
              cnt_nxt             = cnt_r + 1'b1;
              out_nxt.status      = bkv_pkg::ST_INSERTED;
              out_nxt.entry_count = bkv_pkg::ECOUNT_W'(cnt_r + 1'b1);
            end else begin
              out_nxt.status = bkv_pkg::ST_FULL;
            end
          end else begin
            out_nxt.status = bkv_pkg::ST_ABSENT;
          end
          pend_v_nxt    = 1'b0;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          // issue the next key read
          mem_req.re  = 1'b1;
          cmp_idx_nxt = rd_idx_r[bkv_pkg::IDX_W-1:0];
          rd_idx_nxt  = rd_idx_r + 1'b1;
          pend_v_nxt  = 1'b1;
        end
      end

      S_VREAD: begin
        out_nxt.data_out    = rval;
        out_nxt.status      = bkv_pkg::ST_FOUND;
        out_nxt.entry_count = bkv_pkg::ECOUNT_W'(cnt_r);
        out_valid_nxt       = 1'b1;
        state_nxt           = S_IDLE;
      end

      S_MOVE: begin
        // last entry overwrites the removed one, table shrinks by one
        mem_req.kwe         = 1'b1;
        mem_req.vwe         = 1'b1;
        mem_req.waddr       = slot_r;
        mem_req.wkey        = rkey;
        mem_req.wval        = rval;
        cnt_nxt             = last;
        out_nxt.data_out    = '0;
        out_nxt.status      = bkv_pkg::ST_FOUND;
        out_nxt.entry_count = bkv_pkg::ECOUNT_W'(last);
        out_valid_nxt       = 1'b1;
        state_nxt           = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload and scan pointers
  always_ff @(posedge clk) begin
    rd_idx_r  <= rd_idx_nxt;
    cmp_idx_r <= cmp_idx_nxt;
    slot_r    <= slot_nxt;
    in_r      <= in_nxt;
    out_r     <= out_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  // the table never holds more than its capacity
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= bkv_pkg::FULL_CNT)
    else $error("entry count above capacity");

  // a result is only produced by an item that was in progress
  a_out_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result without an item in progress");

  // finishing an item always shows its result
  a_done_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid)
    else $error("item finished without a result");

  // insertion grows the table by exactly one
  a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.status == bkv_pkg::ST_INSERTED)
      |-> (cnt_r == $past(cnt_r) + 1'b1))
    else $error("insert did not grow the table by one");

  // only a found key returns nonzero data
  a_data_only_found: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.data_out != '0) |-> (out_item.status == bkv_pkg::ST_FOUND))
    else $error("nonzero data on a miss");

endmodule

`default_nettype wire
